// File: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int unsigned DEQ_DEPTH = 16;  // default number of entries
    localparam int unsigned WORD_W    = 32;  // stored word width
    localparam int unsigned FUNC_W    = 3;   // operation code width
    localparam int unsigned COUNT_W   = 5;   // width of the reported entry count

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
    } result_t;

    // Per-chain control, shared by every cell of one chain
    typedef struct packed {
        logic shift_in;   // new word enters at the head, rest move one cell down
        logic shift_out;  // head word leaves, rest move one cell up
        logic load_tail;  // new word written at the cell just past the last entry
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/deq_cell.sv
// One storage cell of a deque chain.
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 5
)
(
    input  wire                     clk,
    input  cell_ctl_t               ctl,
    input  wire [CW-1:0]            count,
    input  wire signed [WORD_W-1:0] from_prev,
    input  wire signed [WORD_W-1:0] from_next,
    input  wire signed [WORD_W-1:0] value,
    output logic signed [WORD_W-1:0] word
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        priority if (ctl.shift_in)
        begin
            word_next = from_prev;
        end
        else if (ctl.shift_out)
        begin
            word_next = from_next;
        end
        else if (ctl.load_tail && (count == CW'(INDEX)))
        begin
            word_next = value;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: sv/deq_chain.sv
// Row of deque cells ordered from one end of the queue; cell 0 is the head.
`default_nettype none

module deq_chain
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = DEQ_DEPTH,
    parameter int unsigned CW    = $clog2(DEQ_DEPTH + 1)
)
(
    input  wire                      clk,
    input  cell_ctl_t                ctl,
    input  wire [CW-1:0]             count,
    input  wire signed [WORD_W-1:0]  value,
    output logic signed [WORD_W-1:0] head
);

    logic signed [WORD_W-1:0] words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] prev_word;
        logic signed [WORD_W-1:0] next_word;

        if (i == 0)
        begin : g_first
            assign prev_word = value;
        end
        else
        begin : g_mid_prev
            assign prev_word = words[i-1];
        end

        // last cell has nothing behind it; on a shift out it just holds
        if (i == DEPTH - 1)
        begin : g_last
            assign next_word = words[i];
        end
        else
        begin : g_mid_next
            assign next_word = words[i+1];
        end

        deq_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count),
            .from_prev (prev_word),
            .from_next (next_word),
            .value     (value),
            .word      (words[i])
        );
    end

    assign head = words[0];

endmodule

`default_nettype wire

// File: sv/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
`default_nettype none

// Bounded deque of DEPTH signed words. A command transfer (start high while
// busy is low) carries an operation and a push word; exactly one result
// follows on the next cycle, shown for that single cycle with done high, and
// the receiver cannot stall it. Busy stays low and a command may be issued
// in every cycle; every operation reads and updates the single count
// register that holds the number of stored entries. Storage is
// two chains of cells: one ordered from the front, one from the back, each
// holding the same entries mirrored. A push at one end shifts that end's
// chain down by one and writes the word into the other chain at the cell
// just past its last entry; a pop takes cell 0 of its own end's chain and
// shifts that chain up, the other chain simply losing its last entry through
// the count. Both ends are therefore read at a fixed cell and no cell ever
// looks further than its neighbours. Popping an empty queue gives status
// empty, pushing onto a full one gives status full; neither changes state.
// Clear empties the queue. Unused operation codes do nothing and report done.
// Stored words have no reset; only the count and done are cleared.

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = DEQ_DEPTH
)
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          done_next;
    result_t       result_reg;
    result_t       result_next;

    logic          accept;
    op_t           op;
    logic          full;
    logic          empty;
    cell_ctl_t     front_ctl;
    cell_ctl_t     back_ctl;
    logic signed [WORD_W-1:0] front_head;
    logic signed [WORD_W-1:0] back_head;

    // operations never stall: never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = op_t'(cmd.func);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // chain control: front chain holds entries from the front, back chain
    // from the back
    always_comb
    begin
        front_ctl = '0;
        back_ctl  = '0;
        if (accept)
        begin
            unique case (op)
                OP_PUSH_BACK:
                begin
                    back_ctl.shift_in   = !full;
                    front_ctl.load_tail = !full;
                end
                OP_PUSH_FRONT:
                begin
                    front_ctl.shift_in = !full;
                    back_ctl.load_tail = !full;
                end
                OP_POP_BACK:
                begin
                    back_ctl.shift_out = !empty;
                end
                OP_POP_FRONT:
                begin
                    front_ctl.shift_out = !empty;
                end
                default:
                begin
                    front_ctl = '0;
                    back_ctl  = '0;
                end
            endcase
        end
    end

    // count and result for this transfer
    always_comb
    begin
        count_next               = count_reg;
        result_next.popped_value = '0;
        result_next.status       = ST_DONE;
        unique case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    count_next               = count_reg - CW'(1);
                    result_next.popped_value = (op == OP_POP_BACK) ? back_head : front_head;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.entry_count = COUNT_W'(count_next);
        if (!accept)
        begin
            count_next = count_reg;
        end
        done_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result payload: no reset, qualified by done
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front_chain (
        .clk   (clk),
        .ctl   (front_ctl),
        .count (count_reg),
        .value (cmd.push_value),
        .head  (front_head)
    );

    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_back_chain (
        .clk   (clk),
        .ctl   (back_ctl),
        .count (count_reg),
        .value (cmd.push_value),
        .head  (back_head)
    );

    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // one result per transfer, in the following cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a command");

    // reported count matches the held count
    a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.entry_count == COUNT_W'(count_reg))
        else $error("reported count differs from held count");

    // refused push only when full, refused pop gives zero word
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> count_reg == CW'(DEPTH))
        else $error("full status while not full");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_DONE) |-> result.popped_value == '0)
        else $error("refused operation returned a word");

endmodule

`default_nettype wire

// File: tb/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random command transfers.
`timescale 1ns / 100ps

module tb_double_ended_queue;
    import deq_pkg::*;

    // Codes five to seven decode to nothing; the block must report done and leave state alone
    localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam int unsigned RANDOM_PER_PHASE = 370;
    localparam int unsigned MAX_GAP          = 20;
    localparam int unsigned CYCLE_LIMIT      = 400000;

    // One command waiting to go out, with the idle cycles that precede it and an
    // optional hold-off until every outstanding result has come back
    typedef struct {
        cmd_t        payload;
        int unsigned gap;
        bit          drain_first;
    } queued_cmd_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    queued_cmd_t cmd_backlog[$];
    result_t     pending_results[$];

    // Shadow of the deque: ring of words, slot of the front entry, entries held
    logic [WORD_W-1:0] shadow_store [DEQ_DEPTH];
    int unsigned       shadow_front;
    int unsigned       shadow_count;

    logic        taken;            // a transfer happened at the last rising edge
    int unsigned cmds_queued   = 0;
    int unsigned cmds_accepted = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned idle_pct      = 0;
    bit          drain_next    = 1'b0;

    double_ended_queue #(
        .DEPTH (DEQ_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs or drops results
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Applies one command to the shadow deque and returns what the block should report
    task automatic predict_deque_op(input cmd_t c, output result_t r);
        int unsigned slot;
        r = '0;
        r.status = ST_DONE;
        case (c.func)
            OP_PUSH_BACK:
                if (shadow_count >= DEQ_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slot = (shadow_front + shadow_count) % DEQ_DEPTH;
                    shadow_store[slot] = c.push_value;
                    shadow_count++;
                end
            OP_PUSH_FRONT:
                if (shadow_count >= DEQ_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    shadow_store[shadow_front] = c.push_value;
                    shadow_count++;
                end
            OP_POP_BACK:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    slot = (shadow_front + shadow_count - 1) % DEQ_DEPTH;
                    r.popped_value = shadow_store[slot];
                    shadow_count--;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped_value = shadow_store[shadow_front];
                    shadow_front = (shadow_front + 1) % DEQ_DEPTH;
                    shadow_count--;
                end
            OP_CLEAR:
            begin
                shadow_front = 0;
                shadow_count = 0;
            end
            default:
                ;
        endcase
        r.entry_count = shadow_count[COUNT_W-1:0];
    endtask

    // Queues a command; the idle gap ahead of it follows the current idle percentage
    task automatic add_cmd(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] v);
        queued_cmd_t q;
        q.payload.func       = f;
        q.payload.push_value = v;
        q.gap                = 0;
        while ($urandom_range(99) < idle_pct && q.gap < MAX_GAP)
            q.gap++;
        q.drain_first = drain_next;
        drain_next    = 1'b0;
        cmd_backlog.push_back(q);
        cmds_queued++;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Driver: changes inputs on the falling edge. A command stays presented until
    // the monitor has seen the transfer; only then is the next one (or an idle) chosen.
    always @(negedge clk)
    begin
        logic        nxt_start;
        queued_cmd_t q;
        nxt_start = 1'b0;
        if (rst_n)
        begin
            if (start && !taken)
                nxt_start = 1'b1;
            else if (cmd_backlog.size() != 0)
            begin
                if (cmd_backlog[0].drain_first && pending_results.size() != 0)
                    ;  // hold off until the deque has answered everything
                else if (cmd_backlog[0].gap != 0)
                begin
                    cmd_backlog[0].drain_first = 1'b0;
                    cmd_backlog[0].gap--;
                end
                else
                begin
                    q = cmd_backlog.pop_front();
                    cmd <= q.payload;
                    nxt_start = 1'b1;
                end
            end
        end
        start <= nxt_start;
    end

    // Monitor: on each rising edge, check the result shown in the cycle just ended,
    // then log the transfer (if any) and its predicted result. Checking first keeps
    // the oldest expectation at the head, as a result shows in the cycle after its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            taken        <= 1'b0;
            shadow_front  = 0;
            shadow_count  = 0;
            for (int i = 0; i < DEQ_DEPTH; i++)
                shadow_store[i] = '0;
        end
        else
        begin
            taken <= start && !busy;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: value %0d status %0d count %0d",
                             $time, result.popped_value, result.status, result.entry_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.popped_value !== want.popped_value
                        || result.status !== want.status
                        || result.entry_count !== want.entry_count)
                    begin
                        error_count++;
                        $display("%0t: expected value/status/count %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.popped_value, want.status, want.entry_count,
                                 result.popped_value, result.status, result.entry_count);
                    end
                end
            end
            if (start && !busy)
            begin
                predict_deque_op(cmd, want);
                pending_results.push_back(want);
                cmds_accepted++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned phase_idle [4];
        int unsigned push_bias;
        int unsigned pick;
        logic [FUNC_W-1:0] f;

        phase_idle = '{0, 60, 0, 26};

        // Directed: pops on empty, extreme words at both ends, fill to full and
        // refuse a push at each end, pops from both ends, spare codes, clear
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_FRONT, 32'hFFFF_FFFF);
        add_cmd(OP_PUSH_BACK, 32'h7FFF_FFFF);
        add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
        add_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF);
        add_cmd(OP_PUSH_FRONT, 32'h0000_0000);
        for (int i = 0; i < DEQ_DEPTH - 4; i++)
            add_cmd((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        add_cmd(OP_PUSH_BACK, 32'h1234_5678);
        add_cmd(OP_PUSH_FRONT, 32'h8765_4321);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_FRONT, '0);
        for (logic [FUNC_W:0] s = {1'b0, OP_SPARE_FIRST}; s <= {1'b0, OP_SPARE_LAST}; s++)
            add_cmd(s[FUNC_W-1:0], $urandom);
        add_cmd(OP_CLEAR, $urandom);

        // Random: runs of commands leaning towards pushes or pops so that the
        // deque swings between empty and full; a little clear and spare-code noise
        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            if (p != 0)
                drain_next = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 30 == 0)
                    push_bias = ($urandom_range(2) == 0) ? 20
                              : (($urandom_range(1) == 0) ? 50 : 80);
                pick = $urandom_range(99);
                if (pick < 2)
                    f = OP_CLEAR;
                else if (pick < 5)
                    f = FUNC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
                else if ($urandom_range(99) < push_bias)
                    f = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else
                    f = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                add_cmd(f, pick_word());
            end
        end

        // Hold reset, then release it on a falling edge, away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != cmds_queued)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
